/* sv/cell_voltage_to_soc_curve_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the cell voltage to state-of-charge block
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CELL_VOLTAGE_TO_SOC_CURVE_DEFINES_SVH
`define CELL_VOLTAGE_TO_SOC_CURVE_DEFINES_SVH

// same-cycle implication
`define CVSOC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cvsoc assertion failed");

// next-cycle implication
`define CVSOC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cvsoc assertion failed");

`endif

/* sv/cvsoc_pkg.sv */
// ---------------------------------------------------------------------------
// Cell voltage to state-of-charge package
// Field types, band codes, thresholds and per-band curve coefficients.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cvsoc_pkg;

    localparam int MV_W   = 13;
    localparam int SOC_W  = 10;
    localparam int BAND_W = 3;
    localparam int A_W    = 21;
    localparam int B_W    = 34;
    localparam int SUM_W  = 48;
    localparam int SQ_W   = 2 * MV_W;
    localparam int U_LSB  = 8;
    localparam int U_W    = 29;
    localparam int K_W    = 30;
    localparam int P_W    = U_W + K_W;
    localparam int RECIP_SHIFT = 48;

    typedef logic [MV_W-1:0]   t_mv;
    typedef logic [SOC_W-1:0]  t_soc;
    typedef logic [BAND_W-1:0] t_band;

    localparam t_band BAND_LOW       = 3'd0;
    localparam t_band BAND_1         = 3'd1;
    localparam t_band BAND_2         = 3'd2;
    localparam t_band BAND_3         = 3'd3;
    localparam t_band BAND_4         = 3'd4;
    localparam t_band BAND_5         = 3'd5;
    localparam t_band BAND_NEAR_FULL = 3'd6;
    localparam t_band BAND_FULL      = 3'd7;

    localparam t_mv MV_FULL      = 13'd4185;
    localparam t_mv MV_NEAR_FULL = 13'd4150;
    localparam t_mv MV_B5        = 13'd4000;
    localparam t_mv MV_B4        = 13'd3600;
    localparam t_mv MV_B3        = 13'd3400;
    localparam t_mv MV_B2        = 13'd3300;
    localparam t_mv MV_B1        = 13'd3200;

    localparam t_soc SOC_FULL      = 10'd1000;
    localparam t_soc SOC_NEAR_FULL = 10'd990;
    localparam t_soc SOC_EMPTY     = 10'd0;

    // rounding offset folded into c; thresholds on the offset sum
    localparam logic signed [SUM_W-1:0] T_POS = 48'sd50000000;
    localparam logic signed [SUM_W-1:0] T_SAT = 48'sd100100000000;
    localparam logic [K_W-1:0]          RECIP_K = 30'd720575941;

    typedef struct packed {
        t_mv   mv;
        t_band band;
    } t_item;

    typedef struct packed {
        logic signed [A_W-1:0]   a;
        logic signed [B_W-1:0]   b;
        logic signed [SUM_W-1:0] c;
    } t_coef;

    // a, 1000*b, 1e6*c + 5e7
    function automatic t_coef coef_of(input t_band band);
        t_coef r;
        case (band)
            BAND_1: begin
                r.a = 21'sd93908;
                r.b = -34'sd583390000;
                r.c = 48'sd906210000000;
            end
            BAND_2: begin
                r.a = 21'sd232640;
                r.b = -34'sd1479200000;
                r.c = 48'sd2351650000000;
            end
            BAND_3: begin
                r.a = 21'sd342830;
                r.b = -34'sd2213000000;
                r.c = 48'sd3572150000000;
            end
            BAND_4: begin
                r.a = -21'sd36370;
                r.b = 34'sd377330000;
                r.c = -48'sd839130000000;
            end
            BAND_5: begin
                r.a = -21'sd569090;
                r.b = 34'sd4715700000;
                r.c = -48'sd9669950000000;
            end
            default: begin
                r.a = '0;
                r.b = '0;
                r.c = '0;
            end
        endcase
        return r;
    endfunction

endpackage

/* sv/cell_voltage_to_soc_curve.sv */
// ---------------------------------------------------------------------------
// Cell voltage to state-of-charge curve
// Converts a cell voltage in mV to state of charge in per-mille.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_cell_mv
//  output  | out       | o_valid / i_stall  | o_soc_permille, o_band
//
//  One transfer per cycle sustained while the output is not stalled;
//  path: front register, queue, five arithmetic stages, output register.
//  Rate is set by the single-stage front register and the back pipeline.
//  Reset clears valid flags, queue pointers and queue count only; no clearing pass.
//  A stalled output freezes the back pipeline; the queue and front
//  register absorb up to QUEUE_DEPTH + 1 items before o_stall rises.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cell_voltage_to_soc_curve #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cvsoc_pkg::t_mv       i_cell_mv,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cvsoc_pkg::t_soc      o_soc_permille,
    output cvsoc_pkg::t_band     o_band
);
    import cvsoc_pkg::*;

    logic  q_full, q_push, q_valid, q_pop;
    t_item f_item, q_item;

    cvsoc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cell_mv (i_cell_mv),
        .i_full    (q_full),
        .o_push    (q_push),
        .o_item    (f_item)
    );

    cvsoc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cvsoc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_soc_permille (o_soc_permille),
        .o_band         (o_band)
    );

endmodule

/* sv/cvsoc_front.sv */
// ---------------------------------------------------------------------------
// Front end
// Accepts voltage samples, classifies the band and hands items to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvsoc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cvsoc_pkg::t_mv       i_cell_mv,
    input  logic                 i_full,
    output logic                 o_push,
    output cvsoc_pkg::t_item     o_item
);
    import cvsoc_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;
    t_band n_band;
    logic  accept;

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (i_cell_mv >= MV_FULL) begin
            n_band = BAND_FULL;
        end else if (i_cell_mv >= MV_NEAR_FULL) begin
            n_band = BAND_NEAR_FULL;
        end else if (i_cell_mv < MV_B1) begin
            n_band = BAND_LOW;
        end else if (i_cell_mv >= MV_B5) begin
            n_band = BAND_5;
        end else if (i_cell_mv >= MV_B4) begin
            n_band = BAND_4;
        end else if (i_cell_mv >= MV_B3) begin
            n_band = BAND_3;
        end else if (i_cell_mv >= MV_B2) begin
            n_band = BAND_2;
        end else begin
            n_band = BAND_1;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.mv   <= i_cell_mv;
            r_item.band <= n_band;
        end
    end

endmodule

/* sv/cvsoc_queue.sv */
// ---------------------------------------------------------------------------
// Item queue
// Short first-in first-out buffer between front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvsoc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cvsoc_pkg::t_item     i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output cvsoc_pkg::t_item     o_item
);
    import cvsoc_pkg::*;
    `include "cell_voltage_to_soc_curve_defines.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `CVSOC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `CVSOC_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !pop, r_count == $past(r_count) + 1'b1)
    `CVSOC_ASSERT_NEXT(a_count_dn, i_clk, i_rst_n, pop && !i_push, r_count == $past(r_count) - 1'b1)

endmodule

/* sv/cvsoc_back.sv */
// ---------------------------------------------------------------------------
// Back end
// Pipelined quadratic evaluation, rounding, saturation and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvsoc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  cvsoc_pkg::t_item     i_q_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cvsoc_pkg::t_soc      o_soc_permille,
    output cvsoc_pkg::t_band     o_band
);
    import cvsoc_pkg::*;
    `include "cell_voltage_to_soc_curve_defines.svh"

    logic en;
    t_coef coef;

    logic                    r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r_o_vld;
    t_band                   r1_band, r2_band, r3_band, r4_band, r5_band;
    logic [SQ_W-1:0]         r1_sq;
    logic signed [A_W-1:0]   r1_a;
    logic signed [SUM_W-1:0] r1_bm, r1_c, r2_am2, r2_bm, r2_c, r3_t;
    logic signed [SUM_W-1:0] n1_bm, n2_am2;
    logic                    r4_sat, r4_pos, r5_sat, r5_pos;
    logic [U_W-1:0]          r4_u;
    logic [P_W-1:0]          r5_p;
    t_soc                    n_soc;

    assign en    = !(r_o_vld && i_stall);
    assign o_pop = en;
    assign coef  = coef_of(i_q_item.band);

    assign n1_bm  = coef.b * $signed({1'b0, i_q_item.mv});
    assign n2_am2 = r1_a * $signed({1'b0, r1_sq});

    always_comb begin
        case (r5_band)
            BAND_FULL:      n_soc = SOC_FULL;
            BAND_NEAR_FULL: n_soc = SOC_NEAR_FULL;
            BAND_LOW:       n_soc = SOC_EMPTY;
            default: begin
                if (r5_sat) begin
                    n_soc = SOC_FULL;
                end else if (!r5_pos) begin
                    n_soc = SOC_EMPTY;
                end else begin
                    n_soc = r5_p[RECIP_SHIFT +: SOC_W];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r1_vld  <= i_q_valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r_o_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_band <= i_q_item.band;
            r1_sq   <= i_q_item.mv * i_q_item.mv;
            r1_a    <= coef.a;
            r1_bm   <= n1_bm;
            r1_c    <= coef.c;

            r2_band <= r1_band;
            r2_am2  <= n2_am2;
            r2_bm   <= r1_bm;
            r2_c    <= r1_c;

            r3_band <= r2_band;
            r3_t    <= r2_am2 + r2_bm + r2_c;

            r4_band <= r3_band;
            r4_sat  <= (r3_t >= T_SAT);
            r4_pos  <= (r3_t > T_POS);
            r4_u    <= r3_t[U_LSB +: U_W];

            r5_band <= r4_band;
            r5_sat  <= r4_sat;
            r5_pos  <= r4_pos;
            r5_p    <= r4_u * RECIP_K;

            o_band         <= r5_band;
            o_soc_permille <= n_soc;
        end
    end

    assign o_valid = r_o_vld;

    `CVSOC_ASSERT_NOW(a_soc_range, i_clk, i_rst_n, r_o_vld, o_soc_permille <= SOC_FULL)
    `CVSOC_ASSERT_NOW(a_low_empty, i_clk, i_rst_n, r_o_vld && o_band == BAND_LOW, o_soc_permille == SOC_EMPTY)
    `CVSOC_ASSERT_NOW(a_top_fixed, i_clk, i_rst_n, r_o_vld && o_band == BAND_FULL, o_soc_permille == SOC_FULL)

endmodule

/* test/soc_curve_checker.sv */
// ---------------------------------------------------------------------------
// State-of-charge curve checker
// Watches both channels of the voltage to state-of-charge block. It predicts
// band and per-mille for every accepted voltage and compares each accepted
// result, in order, with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module soc_curve_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  cvsoc_pkg::t_mv    i_cell_mv,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  cvsoc_pkg::t_soc   i_soc_permille,
    input  cvsoc_pkg::t_band  i_band,
    output int                o_fail_count,
    output int                o_pending
);
    import cvsoc_pkg::*;

    typedef struct packed {
        t_soc  soc;
        t_band band;
    } t_soc_reading;

    t_soc_reading soc_due[$];
    t_soc_reading oldest;
    int           fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = soc_due.size();

    // curve value in percent * 1e9 for millivolts mv, coefficients scaled by 1000
    function automatic longint curve_scaled(input t_band band, input longint mv);
        longint a;
        longint b;
        longint c;
        case (band)
            BAND_1: begin a = 93908;   b = -583390;  c = 906160;   end
            BAND_2: begin a = 232640;  b = -1479200; c = 2351600;  end
            BAND_3: begin a = 342830;  b = -2213000; c = 3572100;  end
            BAND_4: begin a = -36370;  b = 377330;   c = -839180;  end
            BAND_5: begin a = -569090; b = 4715700;  c = -9670000; end
            default: begin a = 0; b = 0; c = 0; end
        endcase
        return a * mv * mv + 1000 * b * mv + 1000000 * c;
    endfunction

    function automatic t_soc_reading predict_soc(input t_mv mv);
        t_soc_reading r;
        longint       n;
        longint       q;
        if (mv >= MV_FULL) begin
            r.band = BAND_FULL;
            r.soc  = SOC_FULL;
        end else if (mv >= MV_NEAR_FULL) begin
            r.band = BAND_NEAR_FULL;
            r.soc  = SOC_NEAR_FULL;
        end else if (mv < MV_B1) begin
            r.band = BAND_LOW;
            r.soc  = SOC_EMPTY;
        end else begin
            if (mv >= MV_B5)      r.band = BAND_5;
            else if (mv >= MV_B4) r.band = BAND_4;
            else if (mv >= MV_B3) r.band = BAND_3;
            else if (mv >= MV_B2) r.band = BAND_2;
            else                  r.band = BAND_1;
            n = curve_scaled(r.band, longint'(mv));
            if (n <= 0) begin
                q = 0;
            end else begin
                q = (n + 64'sd50000000) / 64'sd100000000;
                if (q > 1000) q = 1000;
            end
            r.soc = t_soc'(q);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                soc_due.push_back(predict_soc(i_cell_mv));
            end
            if (i_out_valid && !i_out_stall) begin
                if (soc_due.size() == 0) begin
                    $error("unexpected transfer: soc_permille %0d band %0d",
                           i_soc_permille, i_band);
                    fail_count++;
                end else begin
                    oldest = soc_due.pop_front();
                    if (i_soc_permille !== oldest.soc) begin
                        $error("soc_permille: expected %0d, actual %0d",
                               oldest.soc, i_soc_permille);
                        fail_count++;
                    end
                    if (i_band !== oldest.band) begin
                        $error("band: expected %0d, actual %0d", oldest.band, i_band);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* test/cell_voltage_to_soc_curve_tb.sv */
// ---------------------------------------------------------------------------
// Voltage to state-of-charge block testbench
// Feeds band edges and extremes, then random voltages weighted to the curve
// bands, under three idle and stall patterns; a checker predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cell_voltage_to_soc_curve_tb;
    import cvsoc_pkg::*;

    localparam int RANDOM_PER_PHASE = 200;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_mv   i_cell_mv;
    logic  o_valid;
    logic  i_stall;
    t_soc  o_soc_permille;
    t_band o_band;

    int    fail_count;
    int    pending;
    int    send_idle_pct = 38;
    int    recv_stall_pct = 87;

    t_mv   edge_mv[$] = '{13'd0, 13'd8191, 13'd4096, 13'd5000, 13'd3199, 13'd3200,
                          13'd3299, 13'd3300, 13'd3399, 13'd3400, 13'd3599, 13'd3600,
                          13'd3999, 13'd4000, 13'd4149, 13'd4150, 13'd4184, 13'd4185,
                          13'd3250, 13'd3500, 13'd3800, 13'd4075, 13'd2048};

    always #5 i_clk = ~i_clk;

    cell_voltage_to_soc_curve dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cell_mv      (i_cell_mv),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_soc_permille (o_soc_permille),
        .o_band         (o_band)
    );

    soc_curve_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_cell_mv      (i_cell_mv),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_soc_permille (o_soc_permille),
        .i_band         (o_band),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic t_mv random_mv();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)      return t_mv'($urandom_range(3200, 4184));
        else if (pick < 85) return t_mv'($urandom_range(3100, 4300));
        else                return t_mv'($urandom_range(0, 8191));
    endfunction

    // hold valid and payload until the transfer is taken
    task automatic send_mv(input t_mv mv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cell_mv <= mv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_cell_mv <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_mv[k]) send_mv(edge_mv[k]);
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 38; recv_stall_pct = 87; end
                1: begin send_idle_pct = 87; recv_stall_pct = 38; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (RANDOM_PER_PHASE) send_mv(random_mv());
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("cell_voltage_to_soc_curve_tb: done, clean");
        end else begin
            $display("cell_voltage_to_soc_curve_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("cell_voltage_to_soc_curve_tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/cvsoc_pkg.sv
sv/cvsoc_front.sv
sv/cvsoc_queue.sv
sv/cvsoc_back.sv
sv/cell_voltage_to_soc_curve.sv
test/soc_curve_checker.sv
test/cell_voltage_to_soc_curve_tb.sv
